@@ src/swpd_pkg.sv @@
// Package for the sliding-window power meter: widths, constants, codes and types.
// Used by the stream interfaces and by sliding_window_power_db; depends on nothing.
package swpd_pkg;

  // Sample and window geometry.
  localparam int SAMPLE_BITS = 16;
  localparam int WIN_MAX     = 4096;
  localparam int PTR_W       = $clog2(WIN_MAX);
  localparam int LEN_W       = 13;
  localparam int HOP_W       = 16;
  localparam int FRAME_W     = 16;
  localparam int DB_W        = 16;

  // The sum of squares holds a full window of full-scale squares.
  localparam int SQ_W  = 2 * SAMPLE_BITS - 2;
  localparam int SUM_W = SQ_W + PTR_W + 1;

  // Fixed-point log2: Q30 mantissa, 16 fraction bits in the result.
  localparam int LOG_FRAC_BITS = 16;
  localparam int MANT_FRAC     = 30;
  localparam int MANT_W        = MANT_FRAC + 1;
  localparam int EXP_W         = $clog2(SUM_W);
  localparam int LOG_W         = EXP_W + LOG_FRAC_BITS;
  localparam int CNT_W         = $clog2(LOG_FRAC_BITS);
  localparam int NORM_STEP     = 8;

  // Shared multiplier and the dB scaling.
  localparam int MUL_W     = 32;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int DIFF_W    = LOG_W + 2;
  localparam int V_W       = 48;
  localparam int RND_SHIFT = 24;
  localparam int RES_W     = V_W - RND_SHIFT;
  localparam int LOG_OFFSET      = (2 * SAMPLE_BITS - 2) * (1 << LOG_FRAC_BITS);
  localparam int DB_PER_LOG2_Q16 = 197283;
  localparam int DB_FLOOR_Q8     = -30720;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_LEN = 1'b0,
    REG_HOP_LEN    = 1'b1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_ADD,
    ST_SUB,
    ST_LOAD,
    ST_NORM,
    ST_SQ,
    ST_SQB,
    ST_DIFF,
    ST_MUL,
    ST_RND
  } state_e;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [DB_W-1:0]        db_t;
  typedef logic [FRAME_W-1:0]            frame_t;

  // Magnitude of a two's complement sample; full-scale negative gives 2^(n-1).
  function automatic logic [SAMPLE_BITS-1:0] sample_mag(input logic [SAMPLE_BITS-1:0] s);
    return s[SAMPLE_BITS-1] ? ((~s) + SAMPLE_BITS'(1)) : s;
  endfunction

endpackage

@@ src/swpd_in_if.sv @@
// Input stream interface of the power meter: one audio sample word per handshake.
// Depends on swpd_pkg for the sample type.
interface swpd_in_if import swpd_pkg::*;;
  logic    valid;
  logic    ready;
  sample_t sample;
  logic    restart;

  modport source (output valid, output sample, output restart, input ready);
  modport sink   (input valid, input sample, input restart, output ready);
endinterface

@@ src/swpd_out_if.sv @@
// Output stream interface of the power meter: one power word per handshake.
// Depends on swpd_pkg for the dB and frame types.
interface swpd_out_if import swpd_pkg::*;;
  logic   valid;
  logic   ready;
  db_t    power_db;
  logic   silent;
  frame_t frame_index;

  modport source (output valid, output power_db, output silent, output frame_index,
                  input ready);
  modport sink   (input valid, input power_db, input silent, input frame_index,
                  output ready);
endinterface

@@ src/sliding_window_power_db.sv @@
// Sliding-window power meter in dBFS with an iterative fixed-point log2.
// Depends on swpd_pkg, swpd_in_if and swpd_out_if.
//
// Use: samples arrive on in_i (valid/ready), power words leave on out_o.
// Each sample word updates a ring of the last window_len samples and the
// running sum of their squares. A power word is produced when the window
// first fills and then every hop_len samples, in signed Q7.8 dBFS.
// The block takes one word at a time. A word that produces no output is
// finished after the ring read, the add of the new square and, once the
// window is full, the subtract of the leaving square. A word that produces
// output runs two log2 passes on one shared 32x32 multiplier (none when the
// sum is zero, which gives the floor), each a load step, normalising shifts
// and 16 squaring steps of a square and a bit step, then the difference,
// multiply and round steps. The squaring loops take most of the time.
// A finished power word waits in an output register; if the receiver
// stalls, the next output word holds in the last step until the register
// frees, and in_i.ready stays low meanwhile.
// Reset clears the sum, fill, hop, pointer and frame counters and sets both
// lengths to 441. The ring holds no reset value and needs no clearing pass;
// only entries written since the last reset or restart are used.
// Configuration must be written through cfg_we_i/cfg_idx_i/cfg_wdata_i only
// while the block is idle; the block itself does not enforce this.
module sliding_window_power_db import swpd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  swpd_in_if.sink               in_i,
  swpd_out_if.source            out_o
);

  // Control state.
  state_e             state_q, state_d;
  logic [LEN_W-1:0]   win_len_q;
  logic [HOP_W-1:0]   hop_len_q;
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic [LEN_W-1:0]   fill_q, fill_d;
  logic [HOP_W-1:0]   hop_q, hop_d;
  logic [PTR_W-1:0]   wp_q, wp_d;
  logic [FRAME_W-1:0] frame_q, frame_d;
  logic               out_valid_q, out_valid_d;
  logic               emit_q, emit_d;
  logic               phase_q, phase_d;
  logic               floor_q, floor_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  // Datapath registers.
  logic [SAMPLE_BITS-1:0] sample_q, sample_d;
  logic [SAMPLE_BITS-1:0] rd_q;
  logic [PROD_W-1:0]      prod_q, prod_d;
  logic [SUM_W-1:0]       norm_q, norm_d;
  logic [EXP_W-1:0]       exp_q, exp_d;
  logic [MANT_W-1:0]      mant_q, mant_d;
  logic [LOG_W-1:0]       logr_q, logr_d;
  logic [LOG_W-1:0]       lsum_q, lsum_d;
  logic                   dneg_q, dneg_d;
  logic [DIFF_W-2:0]      dmag_q, dmag_d;
  db_t                    db_q, db_d;
  logic                   silent_q, silent_d;
  frame_t                 out_frame_q, out_frame_d;

  // Sample ring.
  logic [SAMPLE_BITS-1:0] ring_mem [WIN_MAX];
  logic [PTR_W-1:0]       rd_addr;

  // Combinational helpers.
  logic [LEN_W-1:0]       w_eff;
  logic [HOP_W-1:0]       h_eff;
  logic [MUL_W-1:0]       mul_a, mul_b;
  logic [LEN_W-1:0]       fill_inc;
  logic [HOP_W-1:0]       hop_inc;
  logic                   sliding;
  logic [SUM_W-1:0]       load_src;
  logic [MANT_W:0]        sq_val;
  logic                   sq_bit;
  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]      diff_abs;
  logic signed [V_W-1:0]  prod_s, v_val;
  logic signed [RES_W-1:0] q_val;
  logic                   in_acc, out_free;

  localparam logic signed [RES_W-1:0] DB_FLOOR_RES = RES_W'(DB_FLOOR_Q8);
  localparam logic signed [V_W-1:0]   RND_HALF     = V_W'(1) <<< (RND_SHIFT - 1);

  // Effective lengths: zero acts as one, window capped at the ring depth.
  always_comb begin
    if (win_len_q == '0) begin
      w_eff = LEN_W'(1);
    end else if (win_len_q > LEN_W'(WIN_MAX)) begin
      w_eff = LEN_W'(WIN_MAX);
    end else begin
      w_eff = win_len_q;
    end
    h_eff = (hop_len_q == '0) ? HOP_W'(1) : hop_len_q;
  end

  assign in_acc   = in_i.valid && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || out_o.ready;
  assign rd_addr  = wp_q - fill_q[PTR_W-1:0];
  assign fill_inc = fill_q + LEN_W'(1);
  assign hop_inc  = hop_q + HOP_W'(1);
  assign sliding  = (fill_q >= w_eff);
  assign load_src = phase_q ? SUM_W'(fill_q) : sum_q;

  // Shared multiplier operand selection.
  always_comb begin
    case (state_q)
      ST_READ: begin
        mul_a = MUL_W'(sample_mag(sample_q));
        mul_b = MUL_W'(sample_mag(sample_q));
      end
      ST_ADD: begin
        mul_a = MUL_W'(sample_mag(rd_q));
        mul_b = MUL_W'(sample_mag(rd_q));
      end
      ST_SQ: begin
        mul_a = MUL_W'(mant_q);
        mul_b = MUL_W'(mant_q);
      end
      ST_MUL: begin
        mul_a = MUL_W'(dmag_q);
        mul_b = MUL_W'(DB_PER_LOG2_Q16);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = PROD_W'(mul_a) * PROD_W'(mul_b);

  // One squaring step of the log2: keep the Q30 square, halve at two.
  assign sq_val = prod_q[2*MANT_FRAC+1:MANT_FRAC];
  assign sq_bit = sq_val[MANT_W];

  // Log difference less the full-scale offset, and the rounded scaled value.
  assign diff     = $signed({2'b00, lsum_q}) - $signed({2'b00, logr_q})
                    - $signed(DIFF_W'(LOG_OFFSET));
  assign diff_abs = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
  assign prod_s   = $signed(prod_q[V_W-1:0]);
  assign v_val    = (dneg_q ? -prod_s : prod_s) + RND_HALF;
  assign q_val    = v_val[V_W-1:RND_SHIFT];

  // Sequencer: next state and next values of all registers.
  always_comb begin
    state_d     = state_q;
    sum_d       = sum_q;
    fill_d      = fill_q;
    hop_d       = hop_q;
    wp_d        = wp_q;
    frame_d     = frame_q;
    out_valid_d = out_valid_q && !out_o.ready;
    emit_d      = emit_q;
    phase_d     = phase_q;
    floor_d     = floor_q;
    cnt_d       = cnt_q;
    sample_d    = sample_q;
    norm_d      = norm_q;
    exp_d       = exp_q;
    mant_d      = mant_q;
    logr_d      = logr_q;
    lsum_d      = lsum_q;
    dneg_d      = dneg_q;
    dmag_d      = dmag_q;
    db_d        = db_q;
    silent_d    = silent_q;
    out_frame_d = out_frame_q;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          sample_d = in_i.sample;
          if (in_i.restart) begin
            sum_d   = '0;
            fill_d  = '0;
            hop_d   = '0;
            wp_d    = '0;
            frame_d = '0;
          end
          state_d = ST_READ;
        end
      end

      // Ring read of the leaving sample and write of the new one.
      ST_READ: begin
        phase_d = 1'b0;
        floor_d = 1'b0;
        emit_d  = 1'b0;
        state_d = ST_ADD;
      end

      // Add the new square and advance the fill or hop counter.
      ST_ADD: begin
        sum_d = sum_q + prod_q[SUM_W-1:0];
        wp_d  = wp_q + PTR_W'(1);
        if (!sliding) begin
          fill_d = fill_inc;
          if (fill_inc == w_eff) begin
            emit_d = 1'b1;
            hop_d  = '0;
          end
        end else begin
          hop_d = hop_inc;
          if (hop_inc == '0 || hop_inc >= h_eff) begin
            emit_d = 1'b1;
            hop_d  = '0;
          end
        end
        if (emit_d) begin
          frame_d = frame_q + FRAME_W'(1);
        end
        if (sliding) begin
          state_d = ST_SUB;
        end else if (emit_d) begin
          state_d = ST_LOAD;
        end else begin
          state_d = ST_IDLE;
        end
      end

      // Remove the square of the sample that leaves the window.
      ST_SUB: begin
        sum_d   = sum_q - prod_q[SUM_W-1:0];
        state_d = emit_q ? ST_LOAD : ST_IDLE;
      end

      // Start log2 on the sum, then on the fill count; a zero sum is floored.
      ST_LOAD: begin
        if (!phase_q && sum_q == '0) begin
          floor_d = 1'b1;
          state_d = ST_RND;
        end else begin
          norm_d  = load_src;
          exp_d   = EXP_W'(SUM_W - 1);
          state_d = ST_NORM;
        end
      end

      // Normalise: coarse steps while the top byte is clear, then single bits.
      ST_NORM: begin
        if (norm_q[SUM_W-1 -: NORM_STEP] == '0) begin
          norm_d = norm_q << NORM_STEP;
          exp_d  = exp_q - EXP_W'(NORM_STEP);
        end else if (!norm_q[SUM_W-1]) begin
          norm_d = norm_q << 1;
          exp_d  = exp_q - EXP_W'(1);
        end else begin
          mant_d  = norm_q[SUM_W-1 -: MANT_W];
          logr_d  = LOG_W'(exp_q);
          cnt_d   = '0;
          state_d = ST_SQ;
        end
      end

      ST_SQ: begin
        state_d = ST_SQB;
      end

      // One fraction bit per square.
      ST_SQB: begin
        mant_d = sq_bit ? sq_val[MANT_W:1] : sq_val[MANT_W-1:0];
        logr_d = {logr_q[LOG_W-2:0], sq_bit};
        cnt_d  = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(LOG_FRAC_BITS - 1)) begin
          if (!phase_q) begin
            lsum_d  = logr_d;
            phase_d = 1'b1;
            state_d = ST_LOAD;
          end else begin
            state_d = ST_DIFF;
          end
        end else begin
          state_d = ST_SQ;
        end
      end

      ST_DIFF: begin
        dneg_d  = diff[DIFF_W-1];
        dmag_d  = diff_abs[DIFF_W-2:0];
        state_d = ST_MUL;
      end

      ST_MUL: begin
        state_d = ST_RND;
      end

      // Round, floor and clip, then hand the word to the output register.
      ST_RND: begin
        if (out_free) begin
          if (floor_q || q_val < DB_FLOOR_RES) begin
            db_d     = DB_W'(DB_FLOOR_Q8);
            silent_d = 1'b1;
          end else if (q_val > 0) begin
            db_d     = '0;
            silent_d = 1'b0;
          end else begin
            db_d     = q_val[DB_W-1:0];
            silent_d = 1'b0;
          end
          out_frame_d = frame_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Control registers and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len_q   <= LEN_W'(441);
      hop_len_q   <= HOP_W'(441);
      sum_q       <= '0;
      fill_q      <= '0;
      hop_q       <= '0;
      wp_q        <= '0;
      frame_q     <= '0;
      out_valid_q <= 1'b0;
      emit_q      <= 1'b0;
      phase_q     <= 1'b0;
      floor_q     <= 1'b0;
      cnt_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_WINDOW_LEN: win_len_q <= cfg_wdata_i[LEN_W-1:0];
          REG_HOP_LEN:    hop_len_q <= cfg_wdata_i[HOP_W-1:0];
          default: ;
        endcase
      end
      sum_q       <= sum_d;
      fill_q      <= fill_d;
      hop_q       <= hop_d;
      wp_q        <= wp_d;
      frame_q     <= frame_d;
      out_valid_q <= out_valid_d;
      emit_q      <= emit_d;
      phase_q     <= phase_d;
      floor_q     <= floor_d;
      cnt_q       <= cnt_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    sample_q    <= sample_d;
    prod_q      <= prod_d;
    norm_q      <= norm_d;
    exp_q       <= exp_d;
    mant_q      <= mant_d;
    logr_q      <= logr_d;
    lsum_q      <= lsum_d;
    dneg_q      <= dneg_d;
    dmag_q      <= dmag_d;
    db_q        <= db_d;
    silent_q    <= silent_d;
    out_frame_q <= out_frame_d;
  end

  // Sample ring: the read returns the entry as it was before this write.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_READ) begin
      rd_q          <= ring_mem[rd_addr];
      ring_mem[wp_q] <= sample_q;
    end
  end

  // Port drive.
  assign in_i.ready        = (state_q == ST_IDLE);
  assign out_o.valid       = out_valid_q;
  assign out_o.power_db    = db_q;
  assign out_o.silent      = silent_q;
  assign out_o.frame_index = out_frame_q;

endmodule

@@ bench/tb.sv @@
// Self-checking bench for sliding_window_power_db: a directed table, then random phases.
// Depends on swpd_pkg, swpd_in_if, swpd_out_if and the block itself; reads no files.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import swpd_pkg::*;

  localparam int     DRAIN_CYCLES  = 120;
  localparam longint DB_PER_OCTAVE = 197283;
  localparam int     FLOOR_Q8      = -30720;
  localparam int     PHASES        = 12;
  localparam int     DIR_ROWS      = 31;
  localparam int     PEND_DEPTH    = 16;

  typedef struct packed {
    db_t    db;
    logic   silent;
    frame_t frame;
  } power_word_t;

  typedef enum {ROW_WORD, ROW_SET_WIN, ROW_SET_HOP} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic [15:0] val;
    logic        rs;
    bit          typed;
    power_word_t want;
  } dir_row_t;

  typedef enum {STYLE_WIDE, STYLE_SMALL, STYLE_QUIET, STYLE_MIXED} style_e;

  typedef struct {
    logic [15:0] win;
    logic [15:0] hop;
    int          items;
    style_e      style;
    int          mode;
    bit          fresh;
  } phase_t;

  localparam sample_t EDGE_SAMPLES [5] = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'sh0001, 16'shFFFF};

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int send_idle_pct = 11;
  int recv_idle_pct = 64;
  int mismatch_count = 0;

  // Expected power words in order; the writer and the reader each own one count.
  power_word_t pend_buf [PEND_DEPTH];
  int          pend_wr = 0;
  int          pend_rd = 0;

  // Private copy of the meter state and its registers.
  sample_t          ring_q [WIN_MAX];
  logic [SUM_W-1:0] sq_sum;
  logic [LEN_W-1:0] fill_n;
  logic [HOP_W-1:0] hop_n;
  logic [PTR_W-1:0] wr_ptr;
  frame_t           frame_n;
  logic [LEN_W-1:0] win_reg;
  logic [HOP_W-1:0] hop_reg;

  dir_row_t dir_plan [DIR_ROWS];
  phase_t   plan [PHASES];

  swpd_in_if  in_if ();
  swpd_out_if out_if ();

  sliding_window_power_db uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  // 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Log one expected power word at the tail.
  function automatic void note_expected(input power_word_t w);
    pend_buf[pend_wr % PEND_DEPTH] = w;
    pend_wr++;
  endfunction

  // Exact square of a signed sample.
  function automatic longint unsigned sample_energy(input sample_t s);
    longint v;
    v = s;
    return v * v;
  endfunction

  // log2 with 16 fraction bits: normalise to a Q30 mantissa, then square and halve.
  function automatic longint log2_q16(input longint unsigned x);
    int              p;
    int              i;
    longint unsigned m;
    longint          r;
    p = 63;
    while (p > 0 && x[p] == 1'b0) p--;
    if (p >= MANT_FRAC) m = x >> (p - MANT_FRAC);
    else m = x << (MANT_FRAC - p);
    r = p;
    for (i = 0; i < LOG_FRAC_BITS; i++) begin
      m = (m * m) >> MANT_FRAC;
      r = r * 2;
      if (m >= (64'd2 << MANT_FRAC)) begin
        m = m >> 1;
        r = r + 1;
      end
    end
    return r;
  endfunction

  // Mean power of the window in Q7.8 dBFS, floored at -120 dB.
  function automatic void db_of_window(input longint unsigned sum, input int n,
                                       output db_t db, output logic floored);
    longint d;
    longint v;
    longint q;
    floored = 1'b0;
    if (sum == 0 || n == 0) begin
      floored = 1'b1;
      db = db_t'(FLOOR_Q8);
      return;
    end
    d = log2_q16(sum) - log2_q16(longint'(n))
        - (longint'(2 * SAMPLE_BITS - 2) <<< LOG_FRAC_BITS);
    v = d * DB_PER_OCTAVE + (longint'(1) <<< (RND_SHIFT - 1));
    if (v >= 0) q = v >>> RND_SHIFT;
    else q = -((-v + ((longint'(1) <<< RND_SHIFT) - 1)) >>> RND_SHIFT);
    if (q < FLOOR_Q8) begin
      floored = 1'b1;
      q = FLOOR_Q8;
    end else if (q > 0) begin
      q = 0;
    end
    db = db_t'(q);
  endfunction

  // Advance the private state by one sample word and give the power word it causes.
  task automatic predict_word(input sample_t s, input logic rs,
                              output bit produced, output power_word_t word);
    int               w;
    int               h;
    bit               emit;
    logic [PTR_W-1:0] old;
    db_t              db;
    logic             floored;
    w = (win_reg == 0) ? 1 : ((win_reg > WIN_MAX) ? WIN_MAX : int'(win_reg));
    h = (hop_reg == 0) ? 1 : int'(hop_reg);
    emit = 1'b0;
    word = '0;
    if (rs) begin
      sq_sum  = '0;
      fill_n  = '0;
      hop_n   = '0;
      wr_ptr  = '0;
      frame_n = '0;
    end
    if (fill_n < w) begin
      fill_n++;
      if (fill_n == w) begin
        emit = 1'b1;
        hop_n = '0;
      end
    end else begin
      old = wr_ptr - fill_n[PTR_W-1:0];
      sq_sum = sq_sum - sample_energy(ring_q[old]);
      hop_n++;
      if (hop_n == 0 || hop_n >= h) begin
        emit = 1'b1;
        hop_n = '0;
      end
    end
    ring_q[wr_ptr] = s;
    sq_sum = sq_sum + sample_energy(s);
    wr_ptr++;
    produced = emit;
    if (emit) begin
      frame_n++;
      db_of_window(sq_sum, int'(fill_n), db, floored);
      word = '{db: db, silent: floored, frame: frame_n};
    end
  endtask

  function automatic sample_t draw_sample(input style_e st);
    case (st)
      STYLE_WIDE:  return sample_t'($urandom);
      STYLE_SMALL: return sample_t'(int'($urandom_range(0, 16)) - 8);
      STYLE_QUIET: begin
        if ($urandom_range(0, 31) == 0) return sample_t'(int'($urandom_range(0, 4)) - 2);
        return '0;
      end
      default: begin
        case ($urandom_range(0, 3))
          0:       return sample_t'($urandom);
          1:       return sample_t'(int'($urandom_range(0, 16)) - 8);
          2:       return EDGE_SAMPLES[$urandom_range(0, 4)];
          default: return sample_t'(int'($urandom_range(0, 2000)) - 1000);
        endcase
      end
    endcase
  endfunction

  // Offer one sample word, with random idle cycles in front, and log its result.
  task automatic send_word(input sample_t s, input logic rs, input bit typed,
                           input power_word_t want);
    bit          produced;
    power_word_t word;
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid   <= 1'b0;
      in_if.sample  <= sample_t'($urandom);
      in_if.restart <= 1'($urandom);
      @(negedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.sample  <= s;
    in_if.restart <= rs;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    predict_word(s, rs, produced, word);
    if (typed) note_expected(want);
    else if (produced) note_expected(word);
  endtask

  // Hold the sender off until every power word is back and the block has gone quiet.
  task automatic settle_block();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (pend_wr != pend_rd) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [15:0] data);
    settle_block();
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    if (idx == REG_WINDOW_LEN) win_reg = data[LEN_W-1:0];
    else hop_reg = data;
  endtask

  // Receiver stalls.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Compare each accepted power word with the oldest one predicted.
  always @(posedge clk_i) begin
    power_word_t want;
    if (rst_ni === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (pend_wr == pend_rd) begin
        $display("%0t: unexpected power word db %0d silent %0b frame %0d", $time,
                 $signed(out_if.power_db), out_if.silent, out_if.frame_index);
        mismatch_count++;
      end else begin
        want = pend_buf[pend_rd % PEND_DEPTH];
        pend_rd++;
        if (out_if.power_db !== want.db) begin
          $display("%0t: power_db expected %0d got %0d", $time, $signed(want.db),
                   $signed(out_if.power_db));
          mismatch_count++;
        end
        if (out_if.silent !== want.silent) begin
          $display("%0t: silent expected %0b got %0b", $time, want.silent, out_if.silent);
          mismatch_count++;
        end
        if (out_if.frame_index !== want.frame) begin
          $display("%0t: frame_index expected %0d got %0d", $time, want.frame,
                   out_if.frame_index);
          mismatch_count++;
        end
      end
    end
  end

  // Main sequence.
  initial begin
    int  p;
    int  i;
    int  r;
    logic rs;
    rst_ni        = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = REG_WINDOW_LEN;
    cfg_wdata     = '0;
    in_if.valid   = 1'b0;
    in_if.sample  = '0;
    in_if.restart = 1'b0;

    // Private state after reset.
    foreach (ring_q[k]) ring_q[k] = '0;
    sq_sum  = '0;
    fill_n  = '0;
    hop_n   = '0;
    wr_ptr  = '0;
    frame_n = '0;
    win_reg = LEN_W'(441);
    hop_reg = HOP_W'(441);

    // Directed rows. Full-scale negative alone in a one-sample window is exactly 0 dB;
    // an all-zero window sits on the floor with the silence flag.
    dir_plan = '{
      '{ROW_SET_WIN, 16'd1,      1'b0, 1'b0, '0},
      '{ROW_SET_HOP, 16'd1,      1'b0, 1'b0, '0},
      '{ROW_WORD,    16'h8000,   1'b1, 1'b1, '{16'sd0, 1'b0, 16'd1}},
      '{ROW_WORD,    16'h0000,   1'b0, 1'b1, '{db_t'(FLOOR_Q8), 1'b1, 16'd2}},
      '{ROW_WORD,    16'h7FFF,   1'b0, 1'b0, '0},
      '{ROW_WORD,    16'h0001,   1'b0, 1'b0, '0},
      '{ROW_WORD,    16'hFFFF,   1'b0, 1'b0, '0},
      '{ROW_WORD,    16'h5555,   1'b0, 1'b0, '0},
      '{ROW_WORD,    16'hAAAA,   1'b0, 1'b0, '0},
      '{ROW_WORD,    16'h0000,   1'b1, 1'b1, '{db_t'(FLOOR_Q8), 1'b1, 16'd1}},
      '{ROW_SET_WIN, 16'd0,      1'b0, 1'b0, '0},
      '{ROW_WORD,    16'h8000,   1'b0, 1'b1, '{16'sd0, 1'b0, 16'd2}},
      '{ROW_SET_HOP, 16'd0,      1'b0, 1'b0, '0},
      '{ROW_WORD,    16'h0000,   1'b0, 1'b1, '{db_t'(FLOOR_Q8), 1'b1, 16'd3}},
      '{ROW_SET_WIN, 16'd3,      1'b0, 1'b0, '0},
      '{ROW_WORD,    16'd100,    1'b0, 1'b0, '0},
      '{ROW_WORD,    16'hFF9C,   1'b0, 1'b0, '0},
      '{ROW_WORD,    16'd7,      1'b0, 1'b0, '0},
      '{ROW_SET_WIN, 16'd2,      1'b0, 1'b0, '0},
      '{ROW_WORD,    16'd300,    1'b0, 1'b0, '0},
      '{ROW_WORD,    16'h8000,   1'b0, 1'b0, '0},
      '{ROW_SET_WIN, 16'hFFFF,   1'b0, 1'b0, '0},
      '{ROW_WORD,    16'd5,      1'b0, 1'b0, '0},
      '{ROW_WORD,    16'd9,      1'b0, 1'b0, '0},
      '{ROW_WORD,    16'h8000,   1'b1, 1'b0, '0},
      '{ROW_SET_WIN, 16'd2,      1'b0, 1'b0, '0},
      '{ROW_SET_HOP, 16'd3,      1'b0, 1'b0, '0},
      '{ROW_WORD,    16'd1,      1'b0, 1'b0, '0},
      '{ROW_WORD,    16'd2,      1'b0, 1'b0, '0},
      '{ROW_WORD,    16'd3,      1'b0, 1'b0, '0},
      '{ROW_WORD,    16'd4,      1'b0, 1'b0, '0}
    };

    // Random phases; window and hop changes without restart cover growing and
    // shrinking a full window. The quiet phase keeps a long window of mostly
    // zero samples, so the power sits near the floor or on it.
    plan[0]  = '{16'd16, 16'd4, 60, STYLE_MIXED, 0, 1'b1};
    plan[1]  = '{16'd64, 16'd0, 60, STYLE_WIDE, 0, 1'b0};
    plan[2]  = '{16'd8, 16'd3, 40, STYLE_SMALL, 0, 1'b0};
    plan[3]  = '{16'($urandom_range(1, 40)), 16'($urandom_range(1, 10)), 60,
                 STYLE_MIXED, 0, 1'b0};
    plan[4]  = '{16'hE000, 16'($urandom_range(1, 4)), 40, STYLE_WIDE, 1, 1'b0};
    plan[5]  = '{16'($urandom_range(1, 200)), 16'($urandom_range(1, 20)), 60,
                 STYLE_MIXED, 1, 1'b1};
    plan[6]  = '{16'd2, 16'hFFFF, 30, STYLE_WIDE, 1, 1'b0};
    plan[7]  = '{16'($urandom_range(1, 100)), 16'($urandom_range(1, 30)), 60,
                 STYLE_SMALL, 1, 1'b1};
    plan[8]  = '{16'($urandom_range(1, 32)), 16'($urandom_range(1, 8)), 60,
                 STYLE_MIXED, 2, 1'b0};
    plan[9]  = '{16'd200, 16'd5, 220, STYLE_QUIET, 2, 1'b1};
    plan[10] = '{16'd4096, 16'd1, 30, STYLE_WIDE, 2, 1'b0};
    plan[11] = '{16'($urandom_range(1, 64)), 16'($urandom_range(1, 16)), 60,
                 STYLE_MIXED, 2, 1'b1};

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part.
    for (r = 0; r < DIR_ROWS; r++) begin
      case (dir_plan[r].kind)
        ROW_SET_WIN: write_reg(REG_WINDOW_LEN, dir_plan[r].val);
        ROW_SET_HOP: write_reg(REG_HOP_LEN, dir_plan[r].val);
        default:     send_word(sample_t'(dir_plan[r].val), dir_plan[r].rs,
                               dir_plan[r].typed, dir_plan[r].want);
      endcase
    end

    // Random part.
    for (p = 0; p < PHASES; p++) begin
      case (plan[p].mode)
        0: begin
          send_idle_pct = 11;
          recv_idle_pct = 64;
        end
        1: begin
          send_idle_pct = 64;
          recv_idle_pct = 11;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      write_reg(REG_WINDOW_LEN, plan[p].win);
      write_reg(REG_HOP_LEN, plan[p].hop);
      for (i = 0; i < plan[p].items; i++) begin
        rs = (i == 0 && plan[p].fresh) ||
             (plan[p].style != STYLE_QUIET && $urandom_range(0, 149) == 0);
        if (plan[p].style != STYLE_QUIET && $urandom_range(0, 59) == 0) settle_block();
        send_word(draw_sample(plan[p].style), rs, 1'b0, '0);
      end
    end

    settle_block();
    if (mismatch_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #100ms;
    $display("tb: errors");
    $finish;
  end

endmodule
